// ===== rtl/arpc_pkg.sv =====
`timescale 1ns / 1ps

package arpc_pkg;

  // fixed field widths
  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  // cache depth default
  localparam int DEF_CACHE_ENTRIES = 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP  = 2'd2;

  // command codes
  localparam logic CMD_RESOLVE = 1'b0;
  localparam logic CMD_LEARN   = 1'b1;

  // stream widths
  localparam int S_DATA_W = 112;
  localparam int M_DATA_W = 88;

  typedef struct packed {
    logic [IP_W-1:0] own_ip;
    logic [IP_W-1:0] subnet_mask;
    logic [IP_W-1:0] gateway_ip;
  } cfg_t;

endpackage

// ===== rtl/arpc_mem.sv =====
`timescale 1ns / 1ps

module arpc_mem #(
  parameter int CACHE_ENTRIES = arpc_pkg::DEF_CACHE_ENTRIES,
  parameter int IDX_W         = 3
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [IDX_W-1:0]           rd_addr_i,
  output logic [arpc_pkg::IP_W-1:0]  rd_ip_o,
  output logic [arpc_pkg::MAC_W-1:0] rd_mac_o,
  input  logic                       wr_en_i,
  input  logic [IDX_W-1:0]           wr_addr_i,
  input  logic [arpc_pkg::IP_W-1:0]  wr_ip_i,
  input  logic [arpc_pkg::MAC_W-1:0] wr_mac_i
);
  import arpc_pkg::*;

  logic [IP_W-1:0]  ip_mem  [CACHE_ENTRIES];
  logic [MAC_W-1:0] mac_mem [CACHE_ENTRIES];
  logic [IP_W-1:0]  rd_ip_q;
  logic [MAC_W-1:0] rd_mac_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ip_mem[wr_addr_i]  <= wr_ip_i;
      mac_mem[wr_addr_i] <= wr_mac_i;
    end
  end

  // registered read: data is valid in the cycle after rd_en_i
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_ip_q  <= ip_mem[rd_addr_i];
      rd_mac_q <= mac_mem[rd_addr_i];
    end
  end

  assign rd_ip_o  = rd_ip_q;
  assign rd_mac_o = rd_mac_q;

endmodule

// ===== rtl/arpc_seq.sv =====
`timescale 1ns / 1ps

module arpc_seq #(
  parameter int CACHE_ENTRIES = arpc_pkg::DEF_CACHE_ENTRIES,
  parameter int IDX_W         = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  arpc_pkg::cfg_t                cfg_i,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic                          s_cmd_i,
  input  logic [arpc_pkg::S_DATA_W-1:0] s_data_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [arpc_pkg::M_DATA_W-1:0] m_data_o,
  output logic                          rd_en_o,
  output logic [IDX_W-1:0]              rd_addr_o,
  input  logic [arpc_pkg::IP_W-1:0]     rd_ip_i,
  input  logic [arpc_pkg::MAC_W-1:0]    rd_mac_i,
  output logic                          wr_en_o,
  output logic [IDX_W-1:0]              wr_addr_o,
  output logic [arpc_pkg::IP_W-1:0]     wr_ip_o,
  output logic [arpc_pkg::MAC_W-1:0]    wr_mac_o
);
  import arpc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  logic [1:0]               state_q, state_d;
  logic                     cmd_q, cmd_d;
  logic [IP_W-1:0]          key_q, key_d;
  logic [IP_W-1:0]          hop_q, hop_d;
  logic [MAC_W-1:0]         smac_q, smac_d;
  logic                     tgt_ok_q, tgt_ok_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic                     all_issued_q, all_issued_d;
  logic                     pend_q, pend_d;
  logic [IDX_W-1:0]         pidx_q, pidx_d;
  logic                     found_q, found_d;
  logic [MAC_W-1:0]         fmac_q, fmac_d;
  logic [IDX_W-1:0]         wp_q, wp_d;
  logic [CACHE_ENTRIES-1:0] valid_q, valid_d;
  logic                     m_valid_q, m_valid_d;
  logic [M_DATA_W-1:0]      m_data_q, m_data_d;

  logic [IP_W-1:0]  in_target;
  logic [IP_W-1:0]  in_sender;
  logic [MAC_W-1:0] in_smac;
  logic [IP_W-1:0]  next_hop;
  logic             accept;
  logic             out_free;
  logic             store;
  logic             is_resolve;

  assign in_target = s_data_i[IP_W-1:0];
  assign in_sender = s_data_i[2*IP_W-1:IP_W];
  assign in_smac   = s_data_i[2*IP_W+MAC_W-1:2*IP_W];

  // on-link destinations go direct, the rest via the gateway
  assign next_hop = (((in_target ^ cfg_i.own_ip) & cfg_i.subnet_mask) == '0) ?
                    in_target : cfg_i.gateway_ip;

  assign s_ready_o  = (state_q == ST_IDLE);
  assign accept     = s_valid_i && s_ready_o;
  assign out_free   = !m_valid_q || m_ready_i;
  assign is_resolve = (cmd_q == CMD_RESOLVE);
  assign store      = (state_q == ST_FIN) && out_free && !is_resolve && tgt_ok_q && !found_q;

  assign rd_en_o   = (state_q == ST_SCAN) && !all_issued_q;
  assign rd_addr_o = idx_q;
  assign wr_en_o   = store;
  assign wr_addr_o = wp_q;
  assign wr_ip_o   = key_q;
  assign wr_mac_o  = smac_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    hop_d        = hop_q;
    smac_d       = smac_q;
    tgt_ok_d     = tgt_ok_q;
    idx_d        = idx_q;
    all_issued_d = all_issued_q;
    pend_d       = 1'b0;
    pidx_d       = pidx_q;
    found_d      = found_q;
    fmac_d       = fmac_q;
    wp_d         = wp_q;
    valid_d      = valid_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;

    if (m_valid_q && m_ready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d        = s_cmd_i;
          key_d        = (s_cmd_i == CMD_LEARN) ? in_sender : next_hop;
          hop_d        = next_hop;
          smac_d       = in_smac;
          tgt_ok_d     = (in_target == cfg_i.own_ip);
          idx_d        = '0;
          all_issued_d = 1'b0;
          found_d      = 1'b0;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue reads back to back, compare each result in the cycle after its read
        if (rd_en_o) begin
          pend_d = 1'b1;
          pidx_d = idx_q;
          if (idx_q == LAST_IDX) begin
            all_issued_d = 1'b1;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
        if (pend_q) begin
          if (valid_q[pidx_q] && (rd_ip_i == key_q)) begin
            found_d = 1'b1;
            fmac_d  = rd_mac_i;
            pend_d  = 1'b0;
            state_d = ST_FIN;
          end else if (pidx_q == LAST_IDX) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          if (is_resolve) begin
            m_data_d = {5'b0, 1'b0, !found_q, hop_q,
                        found_q ? fmac_q : {MAC_W{1'b0}}, found_q};
          end else begin
            m_data_d = {5'b0, store, 1'b0, {IP_W{1'b0}}, {MAC_W{1'b0}}, 1'b0};
          end
          if (store) begin
            valid_d[wp_q] = 1'b1;
            wp_d = (wp_q == LAST_IDX) ? '0 : wp_q + IDX_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_q       <= 1'b0;
      all_issued_q <= 1'b0;
      found_q      <= 1'b0;
      wp_q         <= '0;
      valid_q      <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_q       <= pend_d;
      all_issued_q <= all_issued_d;
      found_q      <= found_d;
      wp_q         <= wp_d;
      valid_q      <= valid_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    hop_q    <= hop_d;
    smac_q   <= smac_d;
    tgt_ok_q <= tgt_ok_d;
    idx_q    <= idx_d;
    pidx_q   <= pidx_d;
    fmac_q   <= fmac_d;
    m_data_q <= m_data_d;
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN) && !pend_q)
    else $error("accepted beat did not start a fresh scan");

  a_store_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |=> valid_q[$past(wp_q)])
    else $error("stored entry not marked valid");

  a_no_store_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en_o |=> $stable(wp_q) && $stable(valid_q))
    else $error("write pointer or valid bits moved without a store");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside the finish step");

  a_hit_excludes_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(m_data_q[0] && m_data_q[81]))
    else $error("hit and request both flagged");

endmodule

// ===== rtl/arp_cache_next_hop_resolver_top.sv =====
`timescale 1ns / 1ps

// arp cache next-hop resolver: one result beat for every input beat. a resolve beat
// (tuser 0) routes its destination to itself when on the local subnet, else to the
// gateway, then looks the next hop up in a cache of CACHE_ENTRIES ip/mac pairs (lowest
// matching entry wins) and returns the mac on a hit or flags that an arp request is due.
// a learn beat (tuser 1) stores the sender pair at a round-robin pointer when its target
// is the own address and the sender is not cached yet. the pairs sit in a synchronous
// ram with one read port and one write port, one read per cycle in the walk; each item
// walks the entries from index 0 until a match or the last entry, and the next beat is
// accepted only once the item's result beat is registered, which waits while the
// previous result beat still waits for tready. the learn write happens in the finish
// step after the walk, so a lookup never overlaps a write. the cache is empty after
// reset (valid bits cleared, no clearing pass). configuration registers may only be
// written while no beat is in flight; register index 3 is ignored.

module arp_cache_next_hop_resolver_top #(
  parameter int CACHE_ENTRIES = arpc_pkg::DEF_CACHE_ENTRIES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [arpc_pkg::IP_W-1:0]        cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [0:0]                       s_axis_tuser,  // cmd
  input  logic [arpc_pkg::S_DATA_W-1:0]    s_axis_tdata,  // target_ip, sender_ip, sender_mac
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // hit, mac_out, next_hop_ip, request_needed, learned, zero pad
  output logic [arpc_pkg::M_DATA_W-1:0]    m_axis_tdata
);
  import arpc_pkg::*;

  localparam int IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  cfg_t cfg_q;

  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic [IP_W-1:0]  rd_ip;
  logic [MAC_W-1:0] rd_mac;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  logic [IP_W-1:0]  wr_ip;
  logic [MAC_W-1:0] wr_mac;

  // configuration registers, out-of-range index dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_OWN_IP:      cfg_q.own_ip      <= cfg_data_i;
        CFG_SUBNET_MASK: cfg_q.subnet_mask <= cfg_data_i;
        CFG_GATEWAY_IP:  cfg_q.gateway_ip  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // lookup and learn sequencer with the output register
  arpc_seq #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .IDX_W         (IdxW)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_cmd_i   (s_axis_tuser[0]),
    .s_data_i  (s_axis_tdata),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_ip_i   (rd_ip),
    .rd_mac_i  (rd_mac),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_ip_o   (wr_ip),
    .wr_mac_o  (wr_mac)
  );

  // ip/mac pair store
  arpc_mem #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .IDX_W         (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_ip_o   (rd_ip),
    .rd_mac_o  (rd_mac),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_ip_i   (wr_ip),
    .wr_mac_i  (wr_mac)
  );

endmodule

// ===== verif/arpc_checker.sv =====
`timescale 1ns / 1ps

module arpc_checker #(
  parameter int CACHE_ENTRIES = arpc_pkg::DEF_CACHE_ENTRIES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [arpc_pkg::IP_W-1:0]      cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [0:0]                     s_axis_tuser,
  input  logic [arpc_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [arpc_pkg::M_DATA_W-1:0]  m_axis_tdata,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             results_o,
  output int                             hits_o,
  output int                             learns_o
);
  import arpc_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  hop;
    logic             req;
    logic             learned;
  } hop_result_t;

  // private copy of the cache and the registers
  logic [IP_W-1:0]  cache_ip  [CACHE_ENTRIES];
  logic [MAC_W-1:0] cache_mac [CACHE_ENTRIES];
  bit               cache_used[CACHE_ENTRIES];
  int               wr_ptr;
  cfg_t             regs;

  hop_result_t      due_results[$];
  int               fails, results, hits, learns;

  assign fail_count_o = fails;
  assign results_o    = results;
  assign hits_o       = hits;
  assign learns_o     = learns;

  function automatic int find_slot(input logic [IP_W-1:0] addr);
    for (int i = 0; i < CACHE_ENTRIES; i++)
      if (cache_used[i] && cache_ip[i] == addr) return i;
    return -1;
  endfunction

  function automatic hop_result_t resolve_or_learn(input logic cmd, input logic [IP_W-1:0] tgt,
                                                   input logic [IP_W-1:0] sip,
                                                   input logic [MAC_W-1:0] smac);
    hop_result_t r;
    logic [IP_W-1:0] nh;
    int slot;
    r = '0;
    if (cmd == CMD_RESOLVE) begin
      nh = (((tgt ^ regs.own_ip) & regs.subnet_mask) == '0) ? tgt : regs.gateway_ip;
      slot = find_slot(nh);
      r.hop = nh;
      if (slot >= 0) begin
        r.hit = 1'b1;
        r.mac = cache_mac[slot];
      end else begin
        r.req = 1'b1;
      end
    end else if (tgt == regs.own_ip && find_slot(sip) < 0) begin
      cache_ip[wr_ptr]   = sip;
      cache_mac[wr_ptr]  = smac;
      cache_used[wr_ptr] = 1'b1;
      wr_ptr = (wr_ptr + 1 >= CACHE_ENTRIES) ? 0 : wr_ptr + 1;
      r.learned = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [MAC_W-1:0] want,
                             input logic [MAC_W-1:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    hop_result_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        cache_ip[i]   = '0;
        cache_mac[i]  = '0;
        cache_used[i] = 1'b0;
      end
      wr_ptr = 0;
      regs   = '0;
      due_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit     = m_axis_tdata[0];
        got.mac     = m_axis_tdata[48:1];
        got.hop     = m_axis_tdata[80:49];
        got.req     = m_axis_tdata[81];
        got.learned = m_axis_tdata[82];
        results++;
        if (due_results.size() == 0) begin
          fails++;
          $display("%0t: result beat with nothing due, expected none, got %h", $time,
                   m_axis_tdata);
        end else begin
          want = due_results.pop_front();
          check_field("hit", MAC_W'(want.hit), MAC_W'(got.hit));
          check_field("mac_out", want.mac, got.mac);
          check_field("next_hop_ip", MAC_W'(want.hop), MAC_W'(got.hop));
          check_field("request_needed", MAC_W'(want.req), MAC_W'(got.req));
          check_field("learned", MAC_W'(want.learned), MAC_W'(got.learned));
          check_field("tdata pad", '0, MAC_W'(m_axis_tdata[M_DATA_W-1:83]));
        end
      end
      // a beat taken at the same edge as a register write still sees the old value
      if (s_axis_tvalid && s_axis_tready) begin
        want = resolve_or_learn(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[63:32],
                                s_axis_tdata[111:64]);
        if (want.hit) hits++;
        if (want.learned) learns++;
        due_results.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_OWN_IP:      regs.own_ip      = cfg_data_i;
          CFG_SUBNET_MASK: regs.subnet_mask = cfg_data_i;
          CFG_GATEWAY_IP:  regs.gateway_ip  = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = due_results.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import arpc_pkg::*;

  localparam int                   ENTRIES        = DEF_CACHE_ENTRIES;
  // the write port has room for one index the block ignores
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  // longest legal quiet spell is the receiver hold-off plus one walk
  localparam int                   HOLD_CYCLES    = 300;
  localparam int                   QUIET_LIMIT    = 3000;

  logic                  clk_i, rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [IP_W-1:0]       cfg_data_i;
  logic                  s_axis_tvalid, s_axis_tready;
  logic [0:0]            s_axis_tuser;
  logic [S_DATA_W-1:0]   s_axis_tdata;
  logic                  m_axis_tvalid, m_axis_tready;
  logic [M_DATA_W-1:0]   m_axis_tdata;

  int fail_count, pending, results, hits, learns;

  // stimulus side view of the registers, used to aim beats at the subnet
  logic [IP_W-1:0] cur_local, cur_mask, cur_gw;
  // calm: no idling on either side; hold_off_req: receiver stalls for a long stretch
  bit calm, hold_off_req;
  int quiet;

  arp_cache_next_hop_resolver_top #(.CACHE_ENTRIES(ENTRIES)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  arpc_checker #(.CACHE_ENTRIES(ENTRIES)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results),
    .hits_o(hits), .learns_o(learns)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: too long without any beat on either side ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("arp_cache_next_hop_resolver_top verification failed");
        $finish;
      end
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 7);
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return MAC_W'({$urandom(), $urandom()});
  endfunction

  // one input beat; called and returns at a falling edge, valid left high
  task automatic send_beat(input logic cmd, input logic [IP_W-1:0] tgt,
                           input logic [IP_W-1:0] sip, input logic [MAC_W-1:0] smac);
    if (!calm) begin
      while ($urandom_range(0, 99) < 7) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {smac, sip, tgt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drop valid and let the block drain and finish its last walk
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (ENTRIES + 6) @(negedge clk_i);
  endtask

  // the ignored index is written first each time, then the three real registers
  task automatic apply_config(input logic [IP_W-1:0] loc, input logic [IP_W-1:0] msk,
                              input logic [IP_W-1:0] gw);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= CFG_UNUSED_IDX;
    cfg_data_i <= $urandom();
    @(negedge clk_i);
    cfg_addr_i <= CFG_OWN_IP;
    cfg_data_i <= loc;
    @(negedge clk_i);
    cfg_addr_i <= CFG_SUBNET_MASK;
    cfg_data_i <= msk;
    @(negedge clk_i);
    cfg_addr_i <= CFG_GATEWAY_IP;
    cfg_data_i <= gw;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_local = loc;
    cur_mask  = msk;
    cur_gw    = gw;
    @(negedge clk_i);
  endtask

  // mostly well-formed traffic around a small address pool so the cache
  // keeps hitting, evicting and refusing duplicates; the rest is noise
  task automatic run_traffic(input int count, input int calm_beats, input bit with_hold);
    logic [IP_W-1:0]  pool[12];
    logic [IP_W-1:0]  tgt, sip;
    logic [MAC_W-1:0] smac;
    int               pick;
    for (int i = 0; i < 12; i++) begin
      if (i < 6)       pool[i] = (cur_local & cur_mask) | ($urandom() & ~cur_mask);
      else if (i == 6) pool[i] = cur_gw;
      else if (i == 7) pool[i] = '0;
      else if (i == 8) pool[i] = cur_local;
      else             pool[i] = $urandom();
    end
    for (int n = 0; n < count; n++) begin
      calm = (n < calm_beats);
      if (with_hold && n == count / 3) hold_off_req = 1'b1;
      pick = $urandom_range(0, 99);
      smac = rand_mac();
      if (pick < 45) begin
        // arp response: mostly aimed at us, sometimes one bit off or random
        pick = $urandom_range(0, 99);
        if (pick < 78)      tgt = cur_local;
        else if (pick < 88) tgt = cur_local ^ (32'h1 << $urandom_range(0, 31));
        else                tgt = $urandom();
        sip = ($urandom_range(0, 99) < 75) ? pool[$urandom_range(0, 11)] : $urandom();
        send_beat(CMD_LEARN, tgt, sip, smac);
      end else begin
        // resolve: pool addresses, fresh on-subnet addresses or anything at all
        pick = $urandom_range(0, 99);
        if (pick < 60)      tgt = pool[$urandom_range(0, 11)];
        else if (pick < 80) tgt = (cur_local & cur_mask) | ($urandom() & ~cur_mask);
        else                tgt = $urandom();
        send_beat(CMD_RESOLVE, tgt, $urandom(), smac);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [IP_W-1:0] loc, msk;
    int              prefix;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = '0;
    s_axis_tdata  = '0;
    cur_local     = '0;
    cur_mask      = '0;
    cur_gw        = '0;
    calm          = 1'b0;
    hold_off_req  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset registers: all zero, mask zero so every destination is local
    send_beat(CMD_RESOLVE, '0, '0, '0);          // address zero absent from an empty cache
    send_beat(CMD_LEARN, '0, '0, '1);            // sender zero can still be learnt
    send_beat(CMD_RESOLVE, '0, '1, '1);          // now it hits
    send_beat(CMD_LEARN, '0, '0, '0);            // already cached, refused
    send_beat(CMD_LEARN, 32'h1, 32'h5, rand_mac()); // wrong target, refused
    send_beat(CMD_RESOLVE, '1, '1, '1);          // top address, miss
    settle();

    apply_config(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101);
    // nine new senders: fills the cache and wraps the pointer, evicting the oldest
    for (int i = 1; i <= 9; i++)
      send_beat(CMD_LEARN, cur_local, 32'hC0A8_0100 + i, {16'hA5A5, 24'h0, i[7:0]});
    send_beat(CMD_RESOLVE, 32'hC0A8_0105, '0, '0);  // on-subnet hit
    send_beat(CMD_RESOLVE, 32'hC0A8_0101, '0, '0);  // evicted, miss
    send_beat(CMD_RESOLVE, 32'h0A00_0001, '0, '0);  // off-subnet, gateway not cached
    send_beat(CMD_LEARN, cur_local, 32'hC0A8_0101, '0);
    send_beat(CMD_RESOLVE, 32'h0808_0808, '0, '0);  // gateway now hits
    send_beat(CMD_RESOLVE, cur_local, '0, '0);      // own address not cached
    send_beat(CMD_LEARN, cur_local, 32'hC0A8_0109, '1); // duplicate sender, refused
    send_beat(CMD_RESOLVE, '1, '1, '1);             // off-subnet top address
    run_traffic(400, 0, 1'b0);
    settle();

    // mask zero: everything on-subnet; long receiver hold-off to back the block up
    apply_config('0, '0, '1);
    run_traffic(350, 0, 1'b1);
    settle();

    // full mask: only the own address is local; opens with a stretch of no idling
    apply_config('1, '1, '0);
    run_traffic(350, 200, 1'b0);
    settle();

    // random settings with a random prefix length
    prefix = $urandom_range(1, 31);
    msk    = 32'hFFFF_FFFF << (32 - prefix);
    loc    = $urandom();
    apply_config(loc, msk, (loc & msk) | ($urandom() & ~msk));
    run_traffic(400, 0, 1'b0);
    settle();
    repeat (20) @(negedge clk_i);

    $display("covered %0d result beats over five register settings:", results);
    $display("  %0d cache hits, %0d new entries", hits, learns);
    if (fail_count == 0 && pending == 0) begin
      $display("arp_cache_next_hop_resolver_top verification clean");
    end else begin
      $display("arp_cache_next_hop_resolver_top verification failed");
    end
    $finish;
  end

endmodule
